### sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

  localparam int FIFO_DEPTH_DEF = 4;

  // command field of an input item
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### sv/sha_fifo.sv
`default_nettype none
module sha_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire sha_pkg::item_t wr_item,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output sha_pkg::item_t     rd_item
);
  import sha_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("fifo overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("fifo count");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd) else $error("fifo underflow");
endmodule
`default_nettype wire

### sv/sha_core.sv
`default_nettype none
module sha_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       it_valid,
  output logic            it_ready,
  input  wire sha_pkg::item_t it_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [31:0]     out_digest_word,
  output logic [2:0]      out_word_index,
  output logic            out_last
);
  import sha_pkg::*;

  state_t state_r, state_nxt;
  logic [255:0] h_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [31:0] w_r [16];
  logic [5:0]  fill_r, rnd_r;
  logic [60:0] cnt_r;
  logic [2:0]  oidx_r;
  logic        mark_r;
  logic        len_r;
  logic [7:0]  pbyte;
  logic [7:0]  nb;
  logic        push;
  logic        full;
  logic [31:0] t1, t2, s0, s1, wn;
  logic [63:0] bits;
  logic [63:0] len_sh;
  logic [255:0] h_sh;

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  always_comb begin
    t1 = hh_r + (ror(e_r,6) ^ ror(e_r,11) ^ ror(e_r,25)) +
         ((e_r & f_r) ^ (~e_r & g_r)) + round_k(rnd_r) + w_r[0];
    t2 = (ror(a_r,2) ^ ror(a_r,13) ^ ror(a_r,22)) +
         ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    s0 = ror(w_r[1],7) ^ ror(w_r[1],18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14],17) ^ ror(w_r[14],19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    bits = {cnt_r, 3'b000};
    // length byte for offsets 56..63, most significant first
    len_sh = bits >> {~fill_r[2:0], 3'b000};
    // marker first, then zeros, then the length once offset 56 is reached
    pbyte = !mark_r ? PAD_MARK : (len_r ? len_sh[7:0] : 8'h00);
    nb = (state_r == ST_PAD) ? pbyte : it_item.data_byte;
    h_sh = h_r >> {~oidx_r, 5'b00000};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (it_valid) begin
          if (it_item.command == CMD_FINISH) state_nxt = ST_PAD;
          else if (fill_r == 6'd63) state_nxt = ST_ROUND;
        end
      end
      ST_PAD:   if (fill_r == 6'd63) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = len_r ? ST_EMIT : (mark_r ? ST_PAD : ST_IDLE);
      ST_EMIT:  if (out_ready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    it_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: push = it_valid && (it_item.command == CMD_ABSORB);
      ST_PAD:  push = 1'b1;
      default: push = 1'b0;
    endcase
    full = push && (fill_r == 6'd63);
    out_valid = (state_r == ST_EMIT);
    out_digest_word = h_sh[31:0];
    out_word_index = oidx_r;
    out_last = (oidx_r == 3'd7);
  end

  // block words fill byte by byte, then shift as the schedule window
  always_ff @(posedge clk) begin
    if (push) begin
      w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], nb};
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
    if (full) begin
      {a_r,b_r,c_r,d_r,e_r,f_r,g_r,hh_r} <= h_r;
    end else if (state_r == ST_ROUND) begin
      {a_r,b_r,c_r,d_r,e_r,f_r,g_r,hh_r} <=
        {t1 + t2, a_r, b_r, c_r, d_r + t1, e_r, f_r, g_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r <= INIT_H;
      fill_r <= '0; rnd_r <= '0; cnt_r <= '0; oidx_r <= '0;
      mark_r <= 1'b0; len_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push) fill_r <= fill_r + 1'b1;
      if (push && state_r == ST_IDLE) cnt_r <= cnt_r + 1'b1;
      if (state_r == ST_PAD) begin
        mark_r <= 1'b1;
        if (fill_r == LEN_OFFSET - 6'd1) len_r <= 1'b1;
      end
      // wraps back to zero after the last round
      if (state_r == ST_ROUND) rnd_r <= rnd_r + 1'b1;
      if (state_r == ST_ADD) begin
        h_r <= {h_r[255:224]+a_r, h_r[223:192]+b_r, h_r[191:160]+c_r,
                h_r[159:128]+d_r, h_r[127:96]+e_r, h_r[95:64]+f_r,
                h_r[63:32]+g_r, h_r[31:0]+hh_r};
      end
      if (state_r == ST_EMIT && out_ready) begin
        oidx_r <= oidx_r + 1'b1;
        if (oidx_r == 3'd7) begin
          h_r <= INIT_H; cnt_r <= '0;
          mark_r <= 1'b0; len_r <= 1'b0;
        end
      end
    end
  end

  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> fill_r == '0) else $error("emit with data");
  a_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r != 6'd63) |=> state_r == ST_ROUND)
    else $error("round cut");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    it_ready |-> state_r == ST_IDLE) else $error("ready when busy");
endmodule
`default_nettype wire

### sv/sha256_byte_stream_hasher.sv
`default_nettype none
// channel  | ports                                     | dir
// in       | in_valid in_ready in_command in_data_byte | item in
// out      | out_valid out_ready out_digest_word       | item out
//          | out_word_index out_last                   |
// absorb items are accepted only in the idle state; the 64th byte of a block starts
// the rounds of the single round unit, followed by the add state
// finish pads one byte per cycle, pausing for the rounds between blocks (up to two blocks), then gives 8 items
// synchronous active-low reset restores the initial chaining words
// a small queue holds items while the core compresses
module sha256_byte_stream_hasher #(
  parameter int FIFO_DEPTH = sha_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last
);
  import sha_pkg::*;

  item_t in_item, q_item;
  logic q_valid, q_ready;
  assign in_item = '{command: in_command, data_byte: in_data_byte};

  // front: queue of raw items
  sha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item));

  // back: buffer, padding, rounds, digest
  sha_core u_core (
    .clk, .rst_n, .it_valid(q_valid), .it_ready(q_ready), .it_item(q_item),
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last);

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_word_index))
    else $error("output dropped");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_word_index == 3'd7))) else $error("last flag");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid &&
    out_word_index == $past(out_word_index) + 1'b1) else $error("word order");
endmodule
`default_nettype wire

### sim/sha256_byte_stream_hasher_tb.sv
`default_nettype none
module sha256_byte_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  // no item accepted for this many cycles ends the run
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last;

  sha256_byte_stream_hasher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last(out_last)
  );

  // expected digest word as it should leave the block
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  digest_beat_t digest_queue[$];

  // shadow of the hashing state
  logic [31:0] hash_h[8];
  logic [7:0]  msg_block[64];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;

  int mismatches;
  int items_sent;
  int words_seen;
  int messages_done;
  int idle_cycles;

  localparam logic [31:0] HASH_K[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] HASH_IV[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // 64 rounds over the collected block, folded into hash_h
  task automatic compress_shadow_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
    e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + HASH_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endtask

  task automatic shadow_push(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) compress_shadow_block();
  endtask

  task automatic shadow_reset();
    for (int i = 0; i < 8; i++) hash_h[i] = HASH_IV[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    block_fill = '0;
    msg_len = '0;
  endtask

  // predict the effect of one accepted item
  task automatic predict_hash_item(input logic cmd, input logic [7:0] b);
    logic [63:0] bits;
    digest_beat_t beat;
    if (cmd == CMD_ABSORB) begin
      shadow_push(b);
      msg_len = msg_len + 61'd1;
    end else begin
      bits = {msg_len, 3'b000};
      shadow_push(8'h80);
      while (block_fill != 6'd56) shadow_push(8'h00);
      for (int i = 0; i < 8; i++) shadow_push(bits[8*(7-i) +: 8]);
      for (int i = 0; i < 8; i++) begin
        beat.word = hash_h[i];
        beat.idx  = 3'(i);
        beat.last = (i == 7);
        digest_queue.insert(digest_queue.size(), beat);
      end
      shadow_reset();
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one item onto the input channel, random gap first
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_hash_item(cmd, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // empty message, byte extremes and the known "abc" vector
  task automatic test_directed();
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_ABSORB, 8'h00);
    send_item(CMD_ABSORB, 8'hff);
    send_item(CMD_ABSORB, 8'h55);
    send_item(CMD_ABSORB, 8'haa);
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_ABSORB, 8'h61);
    send_item(CMD_ABSORB, 8'h62);
    send_item(CMD_ABSORB, 8'h63);
    send_item(CMD_FINISH, 8'h5a);
  endtask

  // lengths around the padding boundary: 55 fits, 56 spills to a second block, 64 fills a whole block
  task automatic test_pad_boundary();
    send_message(55);
    send_message(56);
    send_message(64);
  endtask

  // random messages, mostly short and some up to 39 bytes, a few finishes back to back
  task automatic test_random_messages();
    int budget;
    int len;
    budget = 40;
    while (budget > 0) begin
      len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(57, 70);
      if (len > budget - 1) len = budget - 1;
      send_message(len);
      budget -= len + 1;
    end
  endtask

  // result side: random stall per item, check against oldest expectation
  initial begin
    int stall;
    digest_beat_t exp_beat;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words_seen++;
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest item word=%h idx=%0d last=%b",
                   out_digest_word, out_word_index, out_last);
      end else begin
        exp_beat = digest_queue.pop_front();
        if (out_digest_word !== exp_beat.word || out_word_index !== exp_beat.idx ||
            out_last !== exp_beat.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch exp word=%h idx=%0d last=%b got word=%h idx=%0d last=%b",
                     exp_beat.word, exp_beat.idx, exp_beat.last,
                     out_digest_word, out_word_index, out_last);
        end else if (exp_beat.last) begin
          messages_done++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles with no accepted item
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    items_sent = 0;
    words_seen = 0;
    messages_done = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ABSORB;
    in_data_byte = 8'h00;
    shadow_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_pad_boundary();
    test_random_messages();
    in_valid <= 1'b0;

    while (digest_queue.size() != 0) @(posedge clk);
    // trailing window for any stray item
    repeat (200) @(posedge clk);

    $display("sent %0d items, %0d messages hashed, %0d digest words checked",
             items_sent, messages_done, words_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
